### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked on clk and disabled in reset (rst) for every use.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// cons must hold in the same cycle as ante
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// cons must hold in the cycle after ante
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/dca_pkg.sv
// ----------------------------------------------------------------------------
// dca_pkg
// Types and constants shared by the DMA channel arbiter.
// ----------------------------------------------------------------------------
package dca_pkg;

  localparam int CHANNELS  = 16;
  localparam int CHAN_W    = 4;
  localparam int CNT_W     = 5;
  localparam int PRIO_W    = 4;
  localparam int PRIOS_W   = 64;
  localparam int MASK_W    = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ARB_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAN_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAN_PRIOS = 2'd2;

  localparam logic MODE_FIXED = 1'b0;
  localparam logic MODE_RR    = 1'b1;

  localparam logic [CNT_W-1:0]   COUNT_RESET = 5'd16;
  localparam logic [PRIOS_W-1:0] PRIOS_RESET = 64'hFEDC_BA98_7654_3210;

  typedef struct packed {
    logic               mode;
    logic [CNT_W-1:0]   count;
    logic [PRIOS_W-1:0] prios;
  } dca_cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } dca_status_t;

  typedef struct packed {
    logic              grant_valid;
    logic [CHAN_W-1:0] grant_channel;
    logic              priority_conflict;
  } dca_result_t;

endpackage

### rtl/dma_channel_arbiter_unit.sv
// ----------------------------------------------------------------------------
// dma_channel_arbiter_unit
// DMA channel arbiter: round-robin or fixed-priority grant over the channels
// in use, with a duplicate-priority flag.
//
//   channel   handshake                   word
//   request   request_valid/request_stall request_mask
//   result    result_valid/result_stall   grant_valid, grant_channel,
//                                         priority_conflict
//   config    cfg_write                   cfg_index, cfg_data
//
// Fixed priority: walks the n channels in use, one per cycle.
// Round robin: first reduces the start point (last_grant + 1) modulo n
//   by repeated subtraction, then walks the channels in the same way.
// A word with no channel in use skips the walk and goes straight to done.
// Reset is synchronous; only config, result_valid, state and last grant reset.
// result_stall holds a finished word in the sequencer; requests are stalled
//   while a word is in progress.
// ----------------------------------------------------------------------------
module dma_channel_arbiter_unit
  import dca_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 request_valid,
  output logic                 request_stall,
  input  logic [MASK_W-1:0]    request_mask,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic                 grant_valid,
  output logic [CHAN_W-1:0]    grant_channel,
  output logic                 priority_conflict,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PRIOS_W-1:0]   cfg_data
);

  dca_cfg_t    cfg;
  dca_status_t status;
  dca_result_t scan_result;
  logic        accept;
  logic        out_free;
  logic        load;

  assign request_stall = status.busy;
  assign accept        = request_valid && !request_stall;
  assign out_free      = !result_valid || !result_stall;
  assign load          = status.done && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode     <= MODE_FIXED;
      cfg.count    <= COUNT_RESET;
      cfg.prios    <= PRIOS_RESET;
      result_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_ARB_MODE:   cfg.mode  <= cfg_data[0];
          CFG_CHAN_COUNT: cfg.count <= cfg_data[CNT_W-1:0];
          CFG_CHAN_PRIOS: cfg.prios <= cfg_data;
          default: begin
          end
        endcase
      end
      if (load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grant_valid       <= scan_result.grant_valid;
      grant_channel     <= scan_result.grant_channel;
      priority_conflict <= scan_result.priority_conflict;
    end
  end

  dca_scan u_scan (
    .clk          (clk),
    .rst          (rst),
    .start        (accept),
    .request_mask (request_mask),
    .cfg          (cfg),
    .out_free     (out_free),
    .status       (status),
    .result       (scan_result)
  );

endmodule

### rtl/dca_scan.sv
// ----------------------------------------------------------------------------
// dca_scan
// Arbitration sequencer: reduces the round-robin start point by repeated
// subtraction, then walks the channels one per cycle through one shared
// compare step (priority compare, wrap-point compare, duplicate check).
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dca_scan
  import dca_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [MASK_W-1:0] request_mask,
  input  dca_cfg_t          cfg,
  input  logic              out_free,
  output dca_status_t       status,
  output dca_result_t       result
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOD,
    S_SCAN,
    S_DONE
  } state_t;

  state_t              state;
  logic [MASK_W-1:0]   req;
  logic [CNT_W-1:0]    n_r;
  logic [CNT_W-1:0]    pos;
  logic [CHAN_W-1:0]   k;
  logic [CHAN_W-1:0]   last_grant;
  logic                mode_r;
  logic                found_any;
  logic [CHAN_W-1:0]   any_ch;
  logic                found_ge;
  logic [CHAN_W-1:0]   ge_ch;
  logic                fp_found;
  logic [CHAN_W-1:0]   fp_ch;
  logic [PRIO_W-1:0]   best;
  logic [CHANNELS-1:0] seen;
  logic                conflict;

  logic [CNT_W-1:0]    n_sat;
  logic [PRIO_W-1:0]   prio_k;
  logic [CNT_W-1:0]    k_ext;
  logic                res_found;
  logic [CHAN_W-1:0]   sel;

  assign n_sat  = (cfg.count > CNT_W'(CHANNELS)) ? CNT_W'(CHANNELS) : cfg.count;
  assign prio_k = cfg.prios[k*PRIO_W +: PRIO_W];
  assign k_ext  = {1'b0, k};

  assign res_found = (mode_r == MODE_RR) ? found_any : fp_found;
  assign sel       = (mode_r == MODE_RR) ? (found_ge ? ge_ch : any_ch) : fp_ch;

  assign result.grant_valid       = res_found;
  assign result.grant_channel     = res_found ? sel : '0;
  assign result.priority_conflict = conflict;

  assign status.busy = (state != S_IDLE);
  assign status.done = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      last_grant <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            req       <= request_mask;
            n_r       <= n_sat;
            pos       <= {1'b0, last_grant} + CNT_W'(1);
            mode_r    <= cfg.mode;
            k         <= '0;
            found_any <= 1'b0;
            found_ge  <= 1'b0;
            fp_found  <= 1'b0;
            best      <= '0;
            seen      <= '0;
            conflict  <= 1'b0;
            any_ch    <= '0;
            ge_ch     <= '0;
            fp_ch     <= '0;
            if (n_sat == '0) begin
              state <= S_DONE;
            end else if (cfg.mode == MODE_RR) begin
              state <= S_MOD;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_MOD: begin
          if (pos >= n_r) begin
            pos <= pos - n_r;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (seen[prio_k]) begin
            conflict <= 1'b1;
          end
          seen[prio_k] <= 1'b1;
          if (req[k]) begin
            if (!found_any) begin
              found_any <= 1'b1;
              any_ch    <= k;
            end
            if (!found_ge && (k_ext >= pos)) begin
              found_ge <= 1'b1;
              ge_ch    <= k;
            end
            if (!fp_found || (prio_k > best)) begin
              fp_found <= 1'b1;
              fp_ch    <= k;
              best     <= prio_k;
            end
          end
          if (k_ext == n_r - CNT_W'(1)) begin
            state <= S_DONE;
          end else begin
            k <= k + CHAN_W'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            if (res_found) begin
              last_grant <= sel;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_IMPLIES(a_scan_in_range, state == S_SCAN, k_ext < n_r, "scan index past count")
  `ASSERT_IMPLIES(a_rr_start_reduced, (state == S_SCAN) && (mode_r == MODE_RR), pos < n_r,
                  "round-robin start not reduced")
  `ASSERT_NEXT(a_last_grant_upd, (state == S_DONE) && out_free && res_found,
               last_grant == $past(sel), "last grant not updated")
  `ASSERT_IMPLIES(a_single_no_conflict, (state == S_DONE) && (n_r <= CNT_W'(1)), !conflict,
                  "conflict with fewer than two channels")

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// DMA channel arbiter testbench
// Drives request masks into dma_channel_arbiter_unit under random gaps and
// result back-pressure. A local arbiter model predicts every grant word, and
// each result word is checked field by field against the oldest prediction.
// The run covers directed corners, random configurations in both arbitration
// modes and a long result stall that fills the block.
// ----------------------------------------------------------------------------
module testbench;
  import dca_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 request_valid = 1'b0;
  logic                 request_stall;
  logic [MASK_W-1:0]    request_mask = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  logic                 grant_valid;
  logic [CHAN_W-1:0]    grant_channel;
  logic                 priority_conflict;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [PRIOS_W-1:0]   cfg_data = '0;

  dma_channel_arbiter_unit dut (
    .clk(clk),
    .rst(rst),
    .request_valid(request_valid),
    .request_stall(request_stall),
    .request_mask(request_mask),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .grant_valid(grant_valid),
    .grant_channel(grant_channel),
    .priority_conflict(priority_conflict),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // arbiter model state
  logic               mode_q  = MODE_FIXED;
  logic [CNT_W-1:0]   count_q = COUNT_RESET;
  logic [PRIOS_W-1:0] prios_q = PRIOS_RESET;
  logic [CHAN_W-1:0]  last_q  = '0;

  dca_result_t grants_due[$];
  int          errors = 0;
  bit          idle_on = 1'b1;
  int          rx_hold_len = 0;
  int          hold_left = 0;
  int          rx_wait = 0;

  function automatic dca_result_t arbitrate(input logic [MASK_W-1:0] mask);
    int                n;
    int                ch;
    logic              hit;
    logic [PRIO_W-1:0] best;
    logic [PRIO_W-1:0] p;
    logic [15:0]       seen;
    dca_result_t       r;
    n = (count_q > CHANNELS) ? CHANNELS : int'(count_q);
    hit = 1'b0;
    best = '0;
    seen = '0;
    r = '0;
    if (mode_q == MODE_RR) begin
      for (int s = 1; s <= n && !hit; s++) begin
        ch = (int'(last_q) + s) % n;
        if (mask[ch]) begin
          hit = 1'b1;
          r.grant_channel = ch[CHAN_W-1:0];
        end
      end
    end else begin
      for (int c = 0; c < n; c++) begin
        p = prios_q[c*PRIO_W +: PRIO_W];
        if (mask[c] && (!hit || p > best)) begin
          hit = 1'b1;
          best = p;
          r.grant_channel = c[CHAN_W-1:0];
        end
      end
    end
    for (int c = 0; c < n; c++) begin
      p = prios_q[c*PRIO_W +: PRIO_W];
      if (seen[p]) r.priority_conflict = 1'b1;
      seen[p] = 1'b1;
    end
    if (hit) last_q = r.grant_channel;
    r.grant_valid = hit;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  // valid stays high after acceptance; a gap in the next call or wait_drained lowers it
  task automatic send_word(input logic [MASK_W-1:0] mask);
    int gap;
    gap = idle_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      request_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    request_valid <= 1'b1;
    request_mask  <= mask;
    @(posedge clk);
    while (request_stall) @(posedge clk);
    grants_due.push_back(arbitrate(mask));
  endtask

  task automatic wait_drained();
    request_valid <= 1'b0;
    while (grants_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PRIOS_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_ARB_MODE:   mode_q = data[0];
      CFG_CHAN_COUNT: count_q = data[CNT_W-1:0];
      CFG_CHAN_PRIOS: prios_q = data;
      default: ;
    endcase
  endtask

  // result side: check, then pick the next stall level
  always @(posedge clk) begin
    dca_result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (grants_due.size() == 0) begin
        report_mismatch("unexpected word, grant_channel", int'(grant_channel), 0);
      end else begin
        want = grants_due.pop_front();
        if (grant_valid !== want.grant_valid)
          report_mismatch("grant_valid", int'(grant_valid), int'(want.grant_valid));
        if (grant_channel !== want.grant_channel)
          report_mismatch("grant_channel", int'(grant_channel), int'(want.grant_channel));
        if (priority_conflict !== want.priority_conflict)
          report_mismatch("priority_conflict", int'(priority_conflict),
                          int'(want.priority_conflict));
      end
      rx_wait = idle_on ? $urandom_range(0, 16) : 0;
    end
    if (rx_hold_len > 0) begin
      hold_left = rx_hold_len;
      rx_hold_len = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  task automatic test_reset_state();
    send_word(16'h0000);
    send_word(16'hFFFF);
    send_word(16'h0001);
    send_word(16'h8000);
    send_word(16'h0300);
    wait_drained();
  endtask

  task automatic test_fixed_priority();
    write_reg(CFG_CHAN_PRIOS, 64'h0);
    send_word(16'hF0F0);
    wait_drained();
    // channels 3 and 12 tie at the top priority
    write_reg(CFG_CHAN_PRIOS, 64'h000F_0000_0000_F000);
    send_word(16'h1008);
    send_word(16'h1000);
    wait_drained();
    write_reg(CFG_CHAN_PRIOS, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(16'h8001);
    wait_drained();
    write_reg(CFG_CHAN_PRIOS, PRIOS_RESET);
  endtask

  task automatic test_round_robin();
    write_reg(CFG_ARB_MODE, 64'(MODE_RR));
    send_word(16'hFFFF);
    send_word(16'hFFFF);
    send_word(16'hFFFF);
    send_word(16'h8001);
    send_word(16'h8001);
    send_word(16'h0000);
    wait_drained();
  endtask

  task automatic test_channel_count();
    write_reg(CFG_CHAN_COUNT, 64'd0);
    send_word(16'hFFFF);
    wait_drained();
    write_reg(CFG_CHAN_COUNT, 64'd1);
    send_word(16'hFFFF);
    send_word(16'hFFFE);
    wait_drained();
    write_reg(CFG_CHAN_COUNT, 64'd31);
    send_word(16'hFFFF);
    wait_drained();
    write_reg(CFG_CHAN_COUNT, 64'd5);
    send_word(16'hFFE0);
    wait_drained();
  endtask

  // last grant left above a shrunken channel count
  task automatic test_stale_grant();
    write_reg(CFG_CHAN_COUNT, 64'd16);
    send_word(16'h1000);
    wait_drained();
    write_reg(CFG_CHAN_COUNT, 64'd5);
    send_word(16'h001F);
    wait_drained();
  endtask

  task automatic test_bad_index();
    write_reg(CFG_SPARE, {$urandom(), $urandom()});
    send_word(16'hFFFF);
    wait_drained();
  endtask

  task automatic test_random_phases();
    logic [PRIOS_W-1:0] prios;
    logic [CNT_W-1:0]   cnt;
    logic [MASK_W-1:0]  mask;
    logic [MASK_W-1:0]  span;
    logic [PRIO_W-1:0]  perm[16];
    logic [PRIO_W-1:0]  tmp;
    int                 pick;
    int                 j;
    for (int phase = 0; phase < 12; phase++) begin
      idle_on = (phase % 3) != 0;
      pick = $urandom_range(0, 9);
      if (pick < 7) cnt = CNT_W'($urandom_range(1, 16));
      else if (pick == 7) cnt = '0;
      else if (pick == 8) cnt = CNT_W'($urandom_range(17, 31));
      else cnt = CNT_W'(16);
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        prios = {$urandom(), $urandom()};
      end else if (pick < 7) begin
        for (int i = 0; i < 16; i++) perm[i] = i[PRIO_W-1:0];
        for (int i = 15; i > 0; i--) begin
          j = $urandom_range(0, i);
          tmp = perm[i];
          perm[i] = perm[j];
          perm[j] = tmp;
        end
        for (int i = 0; i < 16; i++) prios[i*PRIO_W +: PRIO_W] = perm[i];
      end else begin
        for (int i = 0; i < 16; i++) prios[i*PRIO_W +: PRIO_W] = PRIO_W'($urandom_range(0, 3));
      end
      write_reg(CFG_ARB_MODE, {$urandom(), $urandom()});
      if ($urandom_range(0, 1))
        write_reg(CFG_CHAN_COUNT, {$urandom(), $urandom() & ~32'h1F} | 64'(cnt));
      else
        write_reg(CFG_CHAN_COUNT, 64'(cnt));
      write_reg(CFG_CHAN_PRIOS, prios);
      span = (cnt >= 16) ? 16'hFFFF : MASK_W'((32'd1 << cnt) - 1);
      for (int k = 0; k < 85; k++) begin
        pick = $urandom_range(0, 19);
        if (pick < 10) mask = MASK_W'($urandom());
        else if (pick < 14) mask = MASK_W'(1 << $urandom_range(0, 15));
        else if (pick < 16) mask = ($urandom_range(0, 1)) ? 16'hFFFF : 16'h0000;
        else mask = MASK_W'($urandom() & $urandom()) & span;
        send_word(mask);
      end
      wait_drained();
    end
    idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    idle_on = 1'b0;
    write_reg(CFG_ARB_MODE, 64'(MODE_RR));
    write_reg(CFG_CHAN_COUNT, 64'd16);
    rx_hold_len = 300;
    for (int k = 0; k < 40; k++) send_word(MASK_W'($urandom()));
    wait_drained();
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_fixed_priority();
    test_round_robin();
    test_channel_count();
    test_stale_grant();
    test_bad_index();
    test_backpressure();
    test_random_phases();
    wait_drained();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
